// ===== rtl/core/bale_pkg.sv =====
// shared types and codes for the bounded array list engine
package bale_pkg;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_REMOVE    = 3'd3;
  localparam logic [2:0] OP_FIND      = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
    logic [2:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         found_index;
    logic signed [31:0] read_data;
    logic [3:0]         fill_count;
  } out_word_t;

  // broadcast command to every cell, already qualified by full / range checks
  typedef struct packed {
    logic ins_front;
    logic ins_back;
    logic remove;
  } cell_cmd_t;

endpackage

// ===== rtl/core/bale_cell.sv =====
// one list cell: holds one entry, shifts with its neighbors, joins find and read chains
module bale_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 4,
  parameter int IDX_W = 3
) (
  input  logic                    clk_i,
  input  bale_pkg::cell_cmd_t     cmd_i,
  input  logic signed [31:0]      value_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic [2:0]              pos_i,
  input  logic signed [31:0]      left_data_i,
  input  logic signed [31:0]      right_data_i,
  output logic signed [31:0]      data_o,
  input  logic                    hit_i,
  input  logic [IDX_W-1:0]        hit_idx_i,
  output logic                    hit_o,
  output logic [IDX_W-1:0]        hit_idx_o,
  input  logic signed [31:0]      rd_i,
  output logic signed [31:0]      rd_o
);
  import bale_pkg::*;

  localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;
  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);
  localparam logic [IDX_W-1:0] MY_TAG = IDX_W'(IDX);

  logic signed [31:0] entry_q, entry_d;
  logic [CMP_W-1:0]   pos_ext, count_ext;
  logic               at_pos, at_count, in_list, match;

  assign pos_ext   = CMP_W'(pos_i);
  assign count_ext = CMP_W'(count_i);
  assign at_pos    = (MY_IDX == pos_ext);
  assign at_count  = (MY_IDX == count_ext);
  assign in_list   = (MY_IDX < count_ext);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_front) begin
      entry_d = left_data_i;
    end else if (cmd_i.ins_back && at_count) begin
      entry_d = value_i;
    end else if (cmd_i.remove && (MY_IDX >= pos_ext)) begin
      entry_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;

  // first match wins: once hit, the index from the left passes through
  assign match     = in_list && (entry_q == value_i);
  assign hit_o     = hit_i | match;
  assign hit_idx_o = hit_i ? hit_idx_i : MY_TAG;

  assign rd_o = at_pos ? entry_q : rd_i;

endmodule

// ===== rtl/core/bounded_array_list_engine.sv =====
// top level of the bounded array list engine: fill count, command decode, result register
//
// usage
//   a command word (opcode, value, position) is taken at a rising edge with start_i high
//   and busy_o low. busy_o stays low: one word can be taken every cycle.
//   the result word appears on result_o in the cycle after the command is taken, marked by
//   done_o for exactly one cycle. the receiver cannot stall, so it must take it then.
//   throughput is one word per cycle. it is set by the row of cells: every cell shifts or
//   loads its entry in the same cycle, and find and read ripple through the row as a chain
//   of cells before the result register.
//   reset clears the fill count and done_o. entry contents are left as they are and are
//   never shown before being written, since reads and finds only look below the count.
//   full inserts, removes and reads beyond the count change nothing and report a status.
module bounded_array_list_engine #(
  parameter int LIST_DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bale_pkg::in_word_t  in_word_i,
  output logic                busy_o,
  output logic                done_o,
  output bale_pkg::out_word_t result_o
);
  import bale_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  out_word_t        result_q, result_d;

  logic             accept, full, pos_ok;
  cell_cmd_t        cmd;
  logic [2:0]       op;

  // chain wires between neighboring cells
  logic signed [31:0] data_w [LIST_DEPTH];
  logic               hit_w  [LIST_DEPTH+1];
  logic [IDX_W-1:0]   hidx_w [LIST_DEPTH+1];
  logic signed [31:0] rd_w   [LIST_DEPTH+1];

  // every command finishes in the cycle it is taken
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign op     = in_word_i.opcode;

  assign full   = (count_q == DEPTH_C);
  assign pos_ok = (CMP_W'(in_word_i.position) < CMP_W'(count_q));

  always_comb begin
    cmd           = '0;
    cmd.ins_front = accept && (op == OP_INS_FRONT) && !full;
    cmd.ins_back  = accept && (op == OP_INS_BACK) && !full;
    cmd.remove    = accept && (op == OP_REMOVE) && pos_ok;
  end

  // find and read chains enter at cell zero
  assign hit_w[0]  = 1'b0;
  assign hidx_w[0] = '0;
  assign rd_w[0]   = '0;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic signed [31:0] left_d, right_d;
    // cell zero takes the new value on insert at front
    if (g == 0) begin : g_first
      assign left_d = in_word_i.value;
    end else begin : g_mid
      assign left_d = data_w[g-1];
    end
    // the last cell keeps its entry on remove
    if (g == LIST_DEPTH - 1) begin : g_last
      assign right_d = data_w[g];
    end else begin : g_inner
      assign right_d = data_w[g+1];
    end

    bale_cell #(
      .IDX   (g),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .value_i      (in_word_i.value),
      .count_i      (count_q),
      .pos_i        (in_word_i.position),
      .left_data_i  (left_d),
      .right_data_i (right_d),
      .data_o       (data_w[g]),
      .hit_i        (hit_w[g]),
      .hit_idx_i    (hidx_w[g]),
      .hit_o        (hit_w[g+1]),
      .hit_idx_o    (hidx_w[g+1]),
      .rd_i         (rd_w[g]),
      .rd_o         (rd_w[g+1])
    );
  end

  // next fill count and result word
  always_comb begin
    count_d  = count_q;
    result_d = '0;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          result_d.status = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      OP_REMOVE: begin
        if (pos_ok) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          result_d.status = ST_RANGE;
        end
      end
      OP_FIND: begin
        if (hit_w[LIST_DEPTH]) begin
          result_d.found_index = 3'(hidx_w[LIST_DEPTH]);
        end else begin
          result_d.status = ST_NOTFOUND;
        end
      end
      OP_READ: begin
        if (pos_ok) begin
          result_d.read_data = rd_w[LIST_DEPTH];
        end else begin
          result_d.status = ST_RANGE;
        end
      end
      default: begin
        // unused opcodes leave the list alone
      end
    endcase
    result_d.fill_count = 4'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // a result only follows a taken command
  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("done without a taken command");

  // the fill count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("fill count beyond depth");

  // a full status means the list really was full and stayed so
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == ST_FULL)) |-> (count_q == DEPTH_C))
    else $error("full status with room left");

  // an insert into a list with room grows it by one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((op == OP_INS_FRONT) || (op == OP_INS_BACK)) && !full)
    |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the list");

  // the reported fill count matches the count register
  a_fill_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.fill_count == 4'(count_q)))
    else $error("reported fill count differs from count");

endmodule

// ===== dv/bounded_array_list_engine_test.sv =====
// self-checking testbench for the bounded array list engine
`timescale 1ns / 1ps

module bounded_array_list_engine_test;
  import bale_pkg::*;

  localparam int LIST_DEPTH = 8;
  localparam int GAP_MAX = 18;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int END_WAIT_CYCLES = 4;
  localparam int RANDOM_WORDS = 1400;
  localparam int MISMATCH_REPORTS = 10;

  // opcodes that the package leaves unnamed: the block must ignore them
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // block ports, every input known from time zero
  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  in_word_t  in_word_i = '0;
  logic      busy_o;
  logic      done_o;
  out_word_t result_o;

  // predictor state: own copy of the list
  logic signed [31:0] list_entries [LIST_DEPTH];
  int unsigned        list_count = 0;

  // results still owed by the block, oldest first
  out_word_t expected_words [$];

  int gap_limit = GAP_MAX;
  int words_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int unexpected_results = 0;
  int stall_cycles = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  bounded_array_list_engine #(
    .LIST_DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_word_i(in_word_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  // expected result of one list operation; updates the predictor's list
  function automatic out_word_t predict_list_op(in_word_t w);
    out_word_t r;
    r = '0;
    r.status = ST_OK;
    case (w.opcode)
      OP_INS_FRONT: begin
        if (list_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // every entry moves up one place, the new value lands at the head
          for (int i = list_count; i > 0; i--) list_entries[i] = list_entries[i - 1];
          list_entries[0] = w.value;
          list_count++;
        end
      end
      OP_INS_BACK: begin
        if (list_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_entries[list_count] = w.value;
          list_count++;
        end
      end
      OP_CLEAR: begin
        list_count = 0;
      end
      OP_REMOVE: begin
        if (w.position >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          // later entries close the hole
          for (int i = w.position; i + 1 < list_count; i++) list_entries[i] = list_entries[i + 1];
          list_count--;
        end
      end
      OP_FIND: begin
        // first match wins, found_index stays zero on a miss
        r.status = ST_NOTFOUND;
        for (int i = 0; i < list_count; i++) begin
          if (r.status == ST_NOTFOUND && list_entries[i] == w.value) begin
            r.status = ST_OK;
            r.found_index = i[2:0];
          end
        end
      end
      OP_READ: begin
        if (w.position >= list_count) r.status = ST_RANGE;
        else r.read_data = list_entries[w.position];
      end
      default: begin
        // unused opcodes: nothing changes, ok with the current count
      end
    endcase
    r.fill_count = list_count[3:0];
    return r;
  endfunction

  function automatic in_word_t make_word(logic [2:0] op, logic signed [31:0] value,
                                         logic [2:0] position);
    in_word_t w;
    w.opcode = op;
    w.value = value;
    w.position = position;
    return w;
  endfunction

  // values with many duplicates and both extremes, so find meets repeats
  function automatic logic signed [31:0] draw_list_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3, 4: return $signed($urandom_range(0, 6)) - 32'sd3;
      default: return $urandom;
    endcase
  endfunction

  // sends one command word after a random gap and records its expected result
  task automatic send_list_word(in_word_t w);
    int gap;
    logic [63:0] noise;
    out_word_t r;
    gap = $urandom_range(0, gap_limit);
    if (gap > 0) begin
      // idle bus carries junk so the block must qualify on start_i
      noise = {$urandom, $urandom};
      start_i <= 1'b0;
      in_word_i <= noise[37:0];
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_word_i <= w;
    // busy_o only moves at a rising edge, so its value at the falling edge decides acceptance
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    r = predict_list_op(w);
    expected_words.push_back(r);
    status_seen[r.status]++;
    words_sent++;
  endtask

  // sender holds off until the block has answered every word
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  // result checker: done_o marks a word that must be taken in that very cycle
  always @(posedge clk_i) begin
    out_word_t exp_word;
    if (done_o) begin
      if (expected_words.size() == 0) begin
        unexpected_results++;
        if (mismatches + unexpected_results <= MISMATCH_REPORTS)
          $display("unexpected result word status=%0d idx=%0d data=%0d count=%0d",
                   result_o.status, result_o.found_index, result_o.read_data,
                   result_o.fill_count);
      end else begin
        exp_word = expected_words.pop_front();
        results_checked++;
        if (result_o.status !== exp_word.status ||
            result_o.found_index !== exp_word.found_index ||
            result_o.read_data !== exp_word.read_data ||
            result_o.fill_count !== exp_word.fill_count) begin
          mismatches++;
          if (mismatches + unexpected_results <= MISMATCH_REPORTS)
            $display("mismatch at result %0d: exp status=%0d idx=%0d data=%0d count=%0d, %s",
                     results_checked, exp_word.status, exp_word.found_index,
                     exp_word.read_data, exp_word.fill_count,
                     $sformatf("got status=%0d idx=%0d data=%0d count=%0d",
                               result_o.status, result_o.found_index,
                               result_o.read_data, result_o.fill_count));
        end
      end
    end
  end

  // watchdog: a long run of cycles with no word moving either way means a hang
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", stall_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // read, find, remove and clear on an empty list, and the unused opcodes
  task automatic test_empty_list();
    send_list_word(make_word(OP_READ, 32'sd0, 3'd0));
    send_list_word(make_word(OP_FIND, 32'sd0, 3'd0));
    send_list_word(make_word(OP_REMOVE, 32'sd0, 3'd0));
    send_list_word(make_word(OP_CLEAR, 32'sh7fff_ffff, 3'd7));
    send_list_word(make_word(OP_UNUSED_LO, 32'sh8000_0000, 3'd7));
    send_list_word(make_word(OP_UNUSED_HI, -32'sd1, 3'd5));
  endtask

  // fill from both ends with extreme values, then inserts on a full list
  task automatic test_full_list();
    send_list_word(make_word(OP_INS_FRONT, 32'sh8000_0000, 3'd0));
    send_list_word(make_word(OP_INS_FRONT, 32'sh7fff_ffff, 3'd7));
    send_list_word(make_word(OP_INS_FRONT, -32'sd1, 3'd2));
    send_list_word(make_word(OP_INS_FRONT, 32'sd0, 3'd5));
    send_list_word(make_word(OP_INS_BACK, 32'sh5555_5555, 3'd0));
    send_list_word(make_word(OP_INS_BACK, 32'shaaaa_aaaa, 3'd1));
    send_list_word(make_word(OP_INS_BACK, -32'sd1, 3'd6));
    send_list_word(make_word(OP_INS_BACK, 32'sd1, 3'd3));
    send_list_word(make_word(OP_INS_FRONT, 32'sd42, 3'd0));
    send_list_word(make_word(OP_INS_BACK, 32'sd43, 3'd7));
  endtask

  // reads, finds and removes at the first, last and middle positions and beyond the count
  task automatic test_positions();
    send_list_word(make_word(OP_READ, 32'sd0, 3'd7));
    send_list_word(make_word(OP_FIND, -32'sd1, 3'd0));
    send_list_word(make_word(OP_FIND, 32'sh1234_5678, 3'd0));
    send_list_word(make_word(OP_REMOVE, 32'sd0, 3'd7));
    send_list_word(make_word(OP_REMOVE, 32'sd0, 3'd0));
    send_list_word(make_word(OP_REMOVE, 32'sd0, 3'd3));
    send_list_word(make_word(OP_READ, 32'sd0, 3'd5));
    send_list_word(make_word(OP_REMOVE, 32'sd0, 3'd6));
  endtask

  // random list traffic, biased so the list keeps filling up and draining
  task automatic test_random_traffic(int n_words);
    in_word_t w;
    int unsigned pick;
    int unsigned gap_mode;
    for (int n = 0; n < n_words; n++) begin
      if (n % 64 == 0) begin
        // alternate back-to-back bursts, short gaps and long gaps
        gap_mode = $urandom_range(0, 2);
        gap_limit = (gap_mode == 0) ? 0 : (gap_mode == 1) ? 2 : GAP_MAX;
      end
      if (n > 0 && n % 400 == 0) drain_results();
      pick = $urandom_range(0, 99);
      w.value = draw_list_value();
      w.position = 3'($urandom_range(0, 7));
      if (pick < 22) w.opcode = OP_INS_FRONT;
      else if (pick < 44) w.opcode = OP_INS_BACK;
      else if (pick < 62) w.opcode = OP_REMOVE;
      else if (pick < 76) w.opcode = OP_FIND;
      else if (pick < 93) w.opcode = OP_READ;
      else if (pick < 96) w.opcode = OP_CLEAR;
      else w.opcode = $urandom_range(0, 1) ? OP_UNUSED_LO : OP_UNUSED_HI;
      // mostly valid positions and present values, the rest stay random
      if (list_count > 0 && $urandom_range(0, 4) != 0)
        w.position = 3'($urandom_range(0, list_count - 1));
      if (w.opcode == OP_FIND && list_count > 0 && $urandom_range(0, 4) < 3)
        w.value = list_entries[3'($urandom_range(0, list_count - 1))];
      send_list_word(w);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_full_list();
    test_positions();
    drain_results();
    test_random_traffic(RANDOM_WORDS);

    // all words are in: wait for the last results, then a few quiet cycles
    drain_results();
    repeat (END_WAIT_CYCLES) @(posedge clk_i);

    $display("summary: %0d command words sent, %0d results checked, %0d mismatches",
             words_sent, results_checked, mismatches + unexpected_results);
    $display("summary: status ok %0d, full %0d, out of range %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
             status_seen[ST_NOTFOUND]);
    if (mismatches == 0 && unexpected_results == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== bounded_array_list_engine.f =====
rtl/core/bale_pkg.sv
rtl/core/bale_cell.sv
rtl/core/bounded_array_list_engine.sv
dv/bounded_array_list_engine_test.sv
